// ----- hw/rtl/mrpm_pkg.sv -----
// Shared types and constants for the multichannel RMS and peak meter.
package mrpm_pkg;

  localparam int unsigned NUM_SAMPLES = 8;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned SQ_W        = 32;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned CHAN_W      = 3;
  localparam int unsigned MEAN_W      = 31;
  localparam int unsigned AVG_W       = 40;
  localparam int unsigned PEAK_W      = 19;

  typedef enum logic [2:0] {
    T_IDLE,
    T_ACC,
    T_START,
    T_CALC,
    T_EMIT
  } top_state_e;

  typedef enum logic [2:0] {
    L_IDLE,
    L_DIV1,
    L_MUL1,
    L_MUL2,
    L_MUL3,
    L_MUL4,
    L_SUM,
    L_DIV2
  } lane_state_e;

  typedef struct packed {
    logic load;
    logic acc;
    logic start;
    logic en;
    logic fresh;
  } ctl_t;

  typedef struct packed {
    logic [AVG_W-1:0]  avg;
    logic [PEAK_W-1:0] hold;
    logic [PEAK_W-1:0] peak;
  } res_t;

endpackage

// ----- hw/rtl/mrpm_div.sv -----
// Restoring divider that retires one quotient bit per cycle.
module mrpm_div #(
  parameter int unsigned NUM_W = 54,
  parameter int unsigned DEN_W = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quot_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   rem_sub;

  assign rem_sh  = {rem_q, quot_q[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[NUM_W-2:0], ge};
      rem_q  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- hw/rtl/mrpm_lane.sv -----
// One channel lane: accumulates squares and peak, then computes its level results.
module mrpm_lane import mrpm_pkg::*; #(
  parameter int unsigned FRAME_W = 13,
  parameter int unsigned HIST_W  = 10,
  parameter int unsigned SUM_W   = 43,
  parameter int unsigned NUM_W   = 54,
  parameter int unsigned DEN_W   = 13
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctl_t                       ctl_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [GAIN_W-1:0]          gain_i,
  input  logic [FRAME_W-1:0]         frames_i,
  input  logic [HIST_W-1:0]          hist_i,
  output logic                       done_o,
  output res_t                       res_o
);

  lane_state_e state_q, state_d;

  logic [MAG_W-1:0]          mag_q;
  logic [SUM_W-1:0]          sum_q;
  logic [MAG_W-1:0]          bp_q;
  logic [AVG_W-1:0]          avg_q;
  logic [PEAK_W-1:0]         hold_q;
  logic [GAIN_W-1:0]         gain_q;
  logic [FRAME_W-1:0]        frames_q;
  logic [HIST_W-1:0]         hist_q;
  logic                      en_q;
  logic                      done_q;
  logic [MEAN_W-1:0]         mean_q;
  logic [SQ_W-1:0]           g2_q;
  logic [PEAK_W-1:0]         pk_q;
  logic [AVG_W-1:0]          scaled_q;
  logic [AVG_W+HIST_W-1:0]   p1_q;
  logic [AVG_W+FRAME_W-1:0]  p2_q;

  logic [SAMPLE_W-1:0]       neg;
  logic [SQ_W-1:0]           sq;
  logic [SQ_W-1:0]           pk_raw;
  logic [MEAN_W+SQ_W-1:0]    ms_raw;
  logic [AVG_W-1:0]          avg_new;
  logic [DEN_W-1:0]          den_sum;
  logic                      div_start;
  logic [NUM_W-1:0]          div_num;
  logic [DEN_W-1:0]          div_den;
  logic                      div_done;
  logic [NUM_W-1:0]          div_quot;

  assign neg     = ~sample_i + 1'b1;
  assign sq      = mag_q * mag_q;
  assign pk_raw  = bp_q * gain_q;
  assign ms_raw  = mean_q * g2_q;
  assign den_sum = DEN_W'(hist_q) + DEN_W'(frames_q);

  // With an empty history the blend reduces to the new mean square.
  always_comb begin
    if (den_sum == '0) begin
      avg_new = scaled_q;
    end else if (|div_quot[NUM_W-1:AVG_W]) begin
      avg_new = '1;
    end else begin
      avg_new = div_quot[AVG_W-1:0];
    end
  end

  assign div_start = ctl_i.start || (state_q == L_SUM);
  assign div_num   = (state_q == L_SUM) ? NUM_W'(p1_q) + NUM_W'(p2_q) : NUM_W'(sum_q);
  assign div_den   = (state_q == L_SUM) ? den_sum : DEN_W'(frames_i);

  mrpm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE: if (ctl_i.start) state_d = L_DIV1;
      L_DIV1: if (div_done) state_d = L_MUL1;
      L_MUL1: state_d = L_MUL2;
      L_MUL2: state_d = L_MUL3;
      L_MUL3: state_d = L_MUL4;
      L_MUL4: state_d = L_SUM;
      L_SUM:  state_d = L_DIV2;
      L_DIV2: if (div_done) state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      sum_q   <= '0;
      bp_q    <= '0;
      avg_q   <= '0;
      hold_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (ctl_i.acc) begin
        sum_q <= sum_q + SUM_W'(sq);
        if (mag_q > bp_q) bp_q <= mag_q;
      end
      if (ctl_i.start && ctl_i.fresh) begin
        avg_q  <= '0;
        hold_q <= '0;
      end
      if (state_q == L_DIV2 && div_done) begin
        done_q <= 1'b1;
        sum_q  <= '0;
        bp_q   <= '0;
        if (en_q) begin
          avg_q <= avg_new;
          if (pk_q > hold_q) hold_q <= pk_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) mag_q <= sample_i[SAMPLE_W-1] ? neg : sample_i;
    if (ctl_i.start) begin
      gain_q   <= gain_i;
      frames_q <= frames_i;
      hist_q   <= hist_i;
      en_q     <= ctl_i.en;
    end
    unique case (state_q)
      L_DIV1: if (div_done) mean_q <= (frames_q == '0) ? '0 : div_quot[MEAN_W-1:0];
      L_MUL1: begin
        g2_q <= gain_q * gain_q;
        pk_q <= pk_raw[SQ_W-1] ? '1 : pk_raw[SQ_W-2:12];
      end
      L_MUL2: scaled_q <= AVG_W'(ms_raw[MEAN_W+SQ_W-1:24]);
      L_MUL3: p1_q <= avg_q * hist_q;
      L_MUL4: p2_q <= scaled_q * frames_q;
      default: ;
    endcase
  end

  assign done_o     = done_q;
  assign res_o.avg  = avg_q;
  assign res_o.hold = hold_q;
  assign res_o.peak = pk_q;

`ifndef SYNTHESIS
  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.acc |-> state_q == L_IDLE)
    else $error("lane accumulated during a level computation");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == L_IDLE)
    else $error("lane finished without returning to idle");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> state_q == L_IDLE)
    else $error("lane started while busy");
`endif

endmodule

// ----- hw/rtl/multichannel_rms_peak_meter.sv -----
// Top level of the multichannel RMS and peak meter: frame intake, lanes and result merge.
// Usage:
// The input channel takes one audio frame per transaction: eight Q1.15 samples,
// the channel count and Q4.12 gain (both used from the buffer's last frame) and
// a last-frame mark. A transaction completes when in_valid_i is high and
// in_stall_o is low.
// Each frame is taken in the idle state; in the next state every lane squares and
// accumulates its sample, unless MAX_FRAMES frames have already been counted.
// On the last frame of a buffer every lane runs its own serial divider twice
// (mean square, then the history blend), with the multiply states L_MUL1 to
// L_MUL4 and the sum state L_SUM between the two divisions.
// The block then delivers one result per active channel, in channel order, one
// per cycle while out_stall_i is low; last_channel_o marks the final one.
// A stalled result holds in the output register; the next frame can be taken
// once the last result has been loaded there.
// Reset clears all accumulators, averages, held peaks and history at once.
module multichannel_rms_peak_meter import mrpm_pkg::*; #(
  parameter int unsigned CHANNELS    = 8,
  parameter int unsigned MAX_FRAMES  = 4096,
  parameter int unsigned HISTORY_CAP = 512
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_0_i,
  input  logic signed [SAMPLE_W-1:0] sample_1_i,
  input  logic signed [SAMPLE_W-1:0] sample_2_i,
  input  logic signed [SAMPLE_W-1:0] sample_3_i,
  input  logic signed [SAMPLE_W-1:0] sample_4_i,
  input  logic signed [SAMPLE_W-1:0] sample_5_i,
  input  logic signed [SAMPLE_W-1:0] sample_6_i,
  input  logic signed [SAMPLE_W-1:0] sample_7_i,
  input  logic [COUNT_W-1:0]         channel_count_i,
  input  logic [GAIN_W-1:0]          input_gain_i,
  input  logic                       frame_last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [CHAN_W-1:0]          channel_o,
  output logic [AVG_W-1:0]           mean_square_avg_o,
  output logic [PEAK_W-1:0]          held_peak_o,
  output logic [PEAK_W-1:0]          short_peak_o,
  output logic                       last_channel_o
);

  localparam int unsigned FRAME_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned HIST_W  = $clog2(HISTORY_CAP + 1);
  localparam int unsigned DEN_W   = $clog2(HISTORY_CAP + MAX_FRAMES + 1);
  localparam int unsigned SUM_W   = 30 + FRAME_W;
  localparam int unsigned PROD_W  = AVG_W + 1 + ((HIST_W > FRAME_W) ? HIST_W : FRAME_W);
  localparam int unsigned NUM_W   = (PROD_W > SUM_W) ? PROD_W : SUM_W;
  localparam int unsigned LANE_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  top_state_e state_q, state_d;

  logic [FRAME_W-1:0]        frame_cnt_q;
  logic [HIST_W-1:0]         hist_q;
  logic [COUNT_W-1:0]        active_q;
  logic [COUNT_W-1:0]        chans_q;
  logic [GAIN_W-1:0]         gain_q;
  logic                      keep_q;
  logic                      last_q;
  logic [CHAN_W-1:0]         idx_q;
  logic                      out_valid_q;
  logic [CHAN_W-1:0]         out_channel_q;
  res_t                      out_res_q;
  logic                      out_last_q;

  logic                      accept;
  logic                      out_free;
  logic                      emit_now;
  logic                      emit_last;
  logic [COUNT_W-1:0]        chans_clamp;
  logic [DEN_W-1:0]          hist_sum;
  logic signed [SAMPLE_W-1:0] samples [NUM_SAMPLES];
  ctl_t                      lane_ctl [CHANNELS];
  logic [CHANNELS-1:0]       lane_done;
  res_t                      lane_res [CHANNELS];

  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;
  assign samples[6] = sample_6_i;
  assign samples[7] = sample_7_i;

  assign in_stall_o  = (state_q != T_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit_now    = (state_q == T_EMIT) && out_free;
  assign emit_last   = (COUNT_W'(idx_q) + 1'b1) == chans_q;
  assign chans_clamp = (channel_count_i > COUNT_W'(CHANNELS)) ? COUNT_W'(CHANNELS)
                                                               : channel_count_i;
  assign hist_sum    = DEN_W'(hist_q) + DEN_W'(frame_cnt_q);

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    always_comb begin
      lane_ctl[i].load  = accept;
      lane_ctl[i].acc   = (state_q == T_ACC) && keep_q;
      lane_ctl[i].start = (state_q == T_START);
      lane_ctl[i].en    = COUNT_W'(i) < chans_q;
      lane_ctl[i].fresh = (COUNT_W'(i) < chans_q) && (COUNT_W'(i) >= active_q);
    end

    mrpm_lane #(
      .FRAME_W (FRAME_W),
      .HIST_W  (HIST_W),
      .SUM_W   (SUM_W),
      .NUM_W   (NUM_W),
      .DEN_W   (DEN_W)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (lane_ctl[i]),
      .sample_i (samples[i]),
      .gain_i   (gain_q),
      .frames_i (frame_cnt_q),
      .hist_i   (hist_q),
      .done_o   (lane_done[i]),
      .res_o    (lane_res[i])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE:  if (accept) state_d = T_ACC;
      T_ACC:   state_d = last_q ? T_START : T_IDLE;
      T_START: state_d = T_CALC;
      T_CALC:  if (&lane_done) state_d = (chans_q == '0) ? T_IDLE : T_EMIT;
      T_EMIT:  if (emit_now && emit_last) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      frame_cnt_q <= '0;
      hist_q      <= '0;
      active_q    <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && frame_cnt_q < FRAME_W'(MAX_FRAMES)) frame_cnt_q <= frame_cnt_q + 1'b1;
      if (state_q == T_START) begin
        frame_cnt_q <= '0;
        active_q    <= chans_q;
        hist_q      <= (hist_sum > DEN_W'(HISTORY_CAP)) ? HIST_W'(HISTORY_CAP)
                                                       : hist_sum[HIST_W-1:0];
        idx_q       <= '0;
      end
      if (emit_now) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_q + 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      keep_q  <= frame_cnt_q < FRAME_W'(MAX_FRAMES);
      last_q  <= frame_last_i;
      chans_q <= chans_clamp;
      gain_q  <= input_gain_i;
    end
    if (emit_now) begin
      out_channel_q <= idx_q;
      out_res_q     <= lane_res[idx_q[LANE_W-1:0]];
      out_last_q    <= emit_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign channel_o         = out_channel_q;
  assign mean_square_avg_o = out_res_q.avg;
  assign held_peak_o       = out_res_q.hold;
  assign short_peak_o      = out_res_q.peak;
  assign last_channel_o    = out_last_q;

`ifndef SYNTHESIS
  a_emit_has_chans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == T_EMIT |-> chans_q != '0)
    else $error("result emission with no active channel");
  a_hist_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_q <= HIST_W'(HISTORY_CAP))
    else $error("history exceeded its cap");
  a_frame_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_cnt_q <= FRAME_W'(MAX_FRAMES))
    else $error("frame count exceeded the buffer limit");
  a_calc_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == T_CALC |=> state_q != T_ACC)
    else $error("frame intake resumed during level computation");
`endif

endmodule
